[rtl/etc_pkg.sv]
// Shared types and constants for the edge timestamp capture unit.
`default_nettype none
package etc_pkg;

  // Item kinds carried on the input tuser
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_READ   = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] CFG_RISING  = 2'd0;
  localparam logic [1:0] CFG_FALLING = 2'd1;
  localparam logic [1:0] CFG_LINE_EN = 2'd2;

  // Fixed field widths
  localparam int PIN_W    = 16;
  localparam int RLINE_W  = 4;
  localparam int RSLOT_W  = 3;
  localparam int OUT_W    = 32;
  localparam int CNT_W    = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W    = 16;
  localparam int IN_DATA_W  = 24;   // 23 bits of fields, padded to bytes
  localparam int OUT_DATA_W = 144;

  // Input item payload as held in the first stage
  typedef struct packed {
    logic               op;
    logic [PIN_W-1:0]   pins;
    logic [RLINE_W-1:0] rline;
    logic [RSLOT_W-1:0] rslot;
  } in_item_t;

endpackage
`default_nettype wire

[rtl/etc_ram.sv]
// Generic single-write, single-read RAM with registered, write-first read.
`default_nettype none
module etc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // A read at the address being written returns the new data
  always_ff @(posedge clk) begin
    if (re) begin
      if (we && (waddr == raddr)) begin
        rdata <= wdata;
      end else begin
        rdata <= mem[raddr];
      end
    end
  end
endmodule
`default_nettype wire

[rtl/etc_line_rec.sv]
// Per-line capture record: edge times, event count and interval history.
`default_nettype none
module etc_line_rec
  import etc_pkg::*;
#(
  parameter int AVG_DEPTH = 8,
  parameter int TIME_BITS = 32,
  localparam int SLOT_W = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1,
  localparam int FILL_W = $clog2(AVG_DEPTH + 1)
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 fire,
  input  wire logic [TIME_BITS-1:0] now,
  input  wire logic                 rd_en,
  input  wire logic [SLOT_W-1:0]    rd_slot,
  output logic      [TIME_BITS-1:0] last_time,
  output logic      [TIME_BITS-1:0] prev_time,
  output logic      [CNT_W-1:0]     event_count,
  output logic      [FILL_W-1:0]    fill,
  output logic      [TIME_BITS-1:0] rd_interval
);
  logic [TIME_BITS-1:0] last_r, prev_r;
  logic [CNT_W-1:0]     count_r;
  logic [SLOT_W-1:0]    ptr_r;      // count mod AVG_DEPTH
  logic [FILL_W-1:0]    fill_r;     // history slots written so far, saturating
  logic [TIME_BITS-1:0] interval_nxt;

  assign interval_nxt = now - last_r;

  // Record update on a fire
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r  <= '0;
      prev_r  <= '0;
      count_r <= '0;
      ptr_r   <= '0;
      fill_r  <= '0;
    end else if (fire) begin
      prev_r  <= last_r;
      last_r  <= now;
      count_r <= count_r + 1'b1;
      // slot pointer follows the count, including its wrap to zero
      if ((count_r == '1) || (ptr_r == SLOT_W'(AVG_DEPTH - 1))) begin
        ptr_r <= '0;
      end else begin
        ptr_r <= ptr_r + 1'b1;
      end
      if (fill_r != FILL_W'(AVG_DEPTH)) begin
        fill_r <= fill_r + 1'b1;
      end
    end
  end

  // Interval history
  etc_ram #(
    .WIDTH (TIME_BITS),
    .DEPTH (AVG_DEPTH)
  ) u_hist (
    .clk   (clk),
    .we    (fire),
    .waddr (ptr_r),
    .wdata (interval_nxt),
    .re    (rd_en),
    .raddr (rd_slot),
    .rdata (rd_interval)
  );

  assign last_time   = last_r;
  assign prev_time   = prev_r;
  assign event_count = count_r;
  assign fill        = fill_r;
endmodule
`default_nettype wire

[rtl/edge_timestamp_capture_unit.sv]
// Top level of the edge timestamp capture unit.
//
// Watches up to LINE_COUNT input lines and timestamps selected edges with a
// free-running tick that advances once per sample item. Each line keeps its
// last and previous edge times, an event count and AVG_DEPTH past intervals.
// Input channel: in_tuser = 0 is a sample (pin levels), 1 is a read of one
//   line's record and one history slot. Output channel: one item per input.
// Configuration: cfg_wr_en writes rising, falling and line enables by index.
// Each input item passes through the input register, then the output
// register. Throughput: one item per cycle while out_tready does not hold the
// output; the line records and history are updated as the input stage hands
// its item to the output register.
// The history RAMs read at input accept so the data lines up with stage one.
// Reset clears tick, prior levels and all records at once; history slots
// not yet written read as zero through a per-line fill count, so no
// clearing pass is needed.
// When out_tready is low the result holds, one further item is taken into
// the input stage, and in_tready then drops until the output drains.
`default_nettype none
module edge_timestamp_capture_unit
  import etc_pkg::*;
#(
  parameter int LINE_COUNT = 16,
  parameter int AVG_DEPTH  = 8,
  parameter int TIME_BITS  = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // Input items
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // pin_levels[15:0], read_line[19:16],
                                                 // read_slot[22:20], zero pad
  input  wire logic                  in_tuser,   // opcode
  // Result items
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic      [OUT_DATA_W-1:0] out_tdata,  // captured_lines[15:0],
                                                 // last_time[47:16],
                                                 // previous_time[79:48],
                                                 // event_count[111:80],
                                                 // interval_value[143:112]
  // Configuration writes
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_W-1:0]      cfg_wr_data
);
  localparam int SLOT_W = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
  localparam int FILL_W = $clog2(AVG_DEPTH + 1);
  localparam int LIDX_W = (LINE_COUNT > 1) ? $clog2(LINE_COUNT) : 1;

  // Configuration
  logic [LINE_COUNT-1:0] rise_en_r, fall_en_r, line_en_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rise_en_r <= '0;
      fall_en_r <= '0;
      line_en_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_RISING:  rise_en_r <= LINE_COUNT'(cfg_wr_data);
        CFG_FALLING: fall_en_r <= LINE_COUNT'(cfg_wr_data);
        CFG_LINE_EN: line_en_r <= LINE_COUNT'(cfg_wr_data);
        default:     ;
      endcase
    end
  end

  // Input stage
  in_item_t s1_item_r;
  logic     s1_valid_r;
  logic     s1_adv;
  logic     in_acc;

  assign s1_adv    = s1_valid_r && (!out_tvalid || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r.op    <= in_tuser;
      s1_item_r.pins  <= in_tdata[PIN_W-1:0];
      s1_item_r.rline <= in_tdata[PIN_W +: RLINE_W];
      s1_item_r.rslot <= in_tdata[PIN_W+RLINE_W +: RSLOT_W];
    end
  end

  // Edge detection on the held sample
  logic [TIME_BITS-1:0]  tick_r;
  logic [LINE_COUNT-1:0] prior_r;
  logic [LINE_COUNT-1:0] pins_v, rise, fall, fire;
  logic                  do_sample;

  assign pins_v    = LINE_COUNT'(s1_item_r.pins);
  assign rise      = pins_v & ~prior_r;
  assign fall      = prior_r & ~pins_v;
  assign fire      = line_en_r & ((rise & rise_en_r) | (fall & fall_en_r));
  assign do_sample = s1_adv && (s1_item_r.op == OP_SAMPLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r  <= '0;
      prior_r <= '0;
    end else if (do_sample) begin
      tick_r  <= tick_r + 1'b1;
      prior_r <= pins_v;
    end
  end

  // Line records
  logic [TIME_BITS-1:0] last_a  [LINE_COUNT];
  logic [TIME_BITS-1:0] prev_a  [LINE_COUNT];
  logic [CNT_W-1:0]     count_a [LINE_COUNT];
  logic [FILL_W-1:0]    fill_a  [LINE_COUNT];
  logic [TIME_BITS-1:0] ival_a  [LINE_COUNT];
  logic [SLOT_W-1:0]    rd_slot;

  assign rd_slot = SLOT_W'(in_tdata[PIN_W+RLINE_W +: RSLOT_W]);

  for (genvar i = 0; i < LINE_COUNT; i++) begin : g_line
    etc_line_rec #(
      .AVG_DEPTH (AVG_DEPTH),
      .TIME_BITS (TIME_BITS)
    ) u_rec (
      .clk         (clk),
      .rst_n       (rst_n),
      .fire        (do_sample && fire[i]),
      .now         (tick_r),
      .rd_en       (in_acc),
      .rd_slot     (rd_slot),
      .last_time   (last_a[i]),
      .prev_time   (prev_a[i]),
      .event_count (count_a[i]),
      .fill        (fill_a[i]),
      .rd_interval (ival_a[i])
    );
  end

  // Result assembly
  logic [LIDX_W-1:0] sel;
  logic              line_ok, slot_ok;
  logic [PIN_W-1:0]  cap_nxt;
  logic [OUT_W-1:0]  last_nxt, prev_nxt, count_nxt, ival_nxt;

  assign sel     = LIDX_W'(s1_item_r.rline);
  assign line_ok = 32'(s1_item_r.rline) < LINE_COUNT;
  assign slot_ok = 32'(s1_item_r.rslot) < 32'(fill_a[sel]);

  always_comb begin
    cap_nxt   = '0;
    last_nxt  = '0;
    prev_nxt  = '0;
    count_nxt = '0;
    ival_nxt  = '0;
    if (s1_item_r.op == OP_SAMPLE) begin
      cap_nxt = PIN_W'(fire);
    end else if (line_ok) begin
      last_nxt  = OUT_W'(last_a[sel]);
      prev_nxt  = OUT_W'(prev_a[sel]);
      count_nxt = OUT_W'(count_a[sel]);
      // slots never written since reset read as zero
      if (slot_ok) begin
        ival_nxt = OUT_W'(ival_a[sel]);
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid <= 1'b0;
    end else if (s1_adv) begin
      out_tvalid <= 1'b1;
    end else if (out_tready) begin
      out_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_tdata <= {ival_nxt, count_nxt, prev_nxt, last_nxt, cap_nxt};
    end
  end
endmodule
`default_nettype wire

[dv/testbench.sv]
// Self-checking testbench for the edge timestamp capture unit: directed, random and stall tests.
`timescale 1ns / 1ps
module testbench;
  import etc_pkg::*;

  localparam int LINES       = 16;
  localparam int HIST_DEPTH  = 8;
  localparam int LATENCY     = 2;
  localparam int HOLD_CYCLES = 200;
  localparam int CYCLE_LIMIT = 400000;

  // Result item as laid out on out_tdata, lowest field last
  typedef struct packed {
    logic [OUT_W-1:0] interval_value;
    logic [OUT_W-1:0] event_count;
    logic [OUT_W-1:0] previous_time;
    logic [OUT_W-1:0] last_time;
    logic [PIN_W-1:0] captured_lines;
  } capture_result_t;

  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  logic                  in_tvalid   = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata    = '0;
  logic                  in_tuser    = OP_SAMPLE;
  logic                  out_tvalid;
  logic                  out_tready  = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_wr_en   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index   = CFG_RISING;
  logic [CFG_W-1:0]      cfg_wr_data = '0;

  edge_timestamp_capture_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wr_data(cfg_wr_data)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Model state: tick, last pin levels, per-line records and interval history
  logic [CFG_W-1:0] rise_en, fall_en, line_en;
  logic [OUT_W-1:0] tick_now;
  logic [PIN_W-1:0] prev_pins;
  logic [OUT_W-1:0] edge_last  [LINES];
  logic [OUT_W-1:0] edge_prev  [LINES];
  logic [CNT_W-1:0] edge_count [LINES];
  logic [OUT_W-1:0] interval_hist [LINES][HIST_DEPTH];

  capture_result_t predicted_records[$];

  int unsigned gap_max   = 0;
  int unsigned stall_max = 0;
  int unsigned hold_seq  = 0;
  int          fail_count = 0;
  int          cycle_count = 0;
  logic [PIN_W-1:0] pin_drive = '0;
  logic             hold_active = 1'b0;

  function automatic void note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endfunction

  function automatic void check_field(input string name, input logic [OUT_W-1:0] want,
                                      input logic [OUT_W-1:0] got);
    if (want !== got)
      note_failure($sformatf("mismatch on %s: expected %08h, got %08h", name, want, got));
  endfunction

  // Advance the model by one item and return the result it gives
  function automatic capture_result_t capture_step(input logic op,
                                                   input logic [PIN_W-1:0] pins,
                                                   input logic [RLINE_W-1:0] rl,
                                                   input logic [RSLOT_W-1:0] rs);
    capture_result_t res;
    logic [PIN_W-1:0] fired;
    logic [2:0] slot;
    int i;
    res = '0;
    if (op == OP_SAMPLE) begin
      fired = line_en & ((pins & ~prev_pins & rise_en) | (prev_pins & ~pins & fall_en));
      for (i = 0; i < LINES; i++) begin
        if (fired[i]) begin
          slot = edge_count[i][2:0];
          edge_prev[i] = edge_last[i];
          edge_last[i] = tick_now;
          interval_hist[i][slot] = tick_now - edge_prev[i];
          edge_count[i] = edge_count[i] + 1;
        end
      end
      prev_pins = pins;
      tick_now = tick_now + 1;
      res.captured_lines = fired;
    end else begin
      res.last_time      = edge_last[rl];
      res.previous_time  = edge_prev[rl];
      res.event_count    = edge_count[rl];
      res.interval_value = interval_hist[rl][rs];
    end
    return res;
  endfunction

  // Offer one item after a random gap and hold it until taken
  task automatic send_item(input logic op, input logic [PIN_W-1:0] pins,
                           input logic [RLINE_W-1:0] rl, input logic [RSLOT_W-1:0] rs);
    int unsigned gap;
    gap = $urandom_range(0, gap_max);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= IN_DATA_W'({rs, rl, pins});
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predicted_records.push_back(capture_step(op, pins, rl, rs));
  endtask

  task automatic sample(input logic [PIN_W-1:0] pins);
    send_item(OP_SAMPLE, pins, '0, '0);
    pin_drive = pins;
  endtask

  task automatic release_input();
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (predicted_records.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  // Registers are only written with nothing in flight
  task automatic set_enables(input logic [CFG_W-1:0] r, input logic [CFG_W-1:0] f,
                             input logic [CFG_W-1:0] l);
    release_input();
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_index   <= CFG_RISING;
    cfg_wr_data <= r;
    @(posedge clk);
    cfg_index   <= CFG_FALLING;
    cfg_wr_data <= f;
    @(posedge clk);
    cfg_index   <= CFG_LINE_EN;
    cfg_wr_data <= l;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    rise_en = r;
    fall_en = f;
    line_en = l;
  endtask

  // Records read back as zero straight after reset
  task automatic test_reset_state();
    gap_max = 0;
    stall_max = 0;
    send_item(OP_READ, '0, 4'd0, 3'd0);
    send_item(OP_READ, 16'hFFFF, 4'd15, 3'd7);
    release_input();
  endtask

  // Edge selection, masking, first sample after reset and history slots
  task automatic test_directed_edges();
    set_enables(16'hFFFF, 16'hFFFF, 16'hFFFF);
    sample(16'hFFFF);           // prior levels are zero: every line rises
    sample(16'hFFFF);
    sample(16'h0000);
    sample(16'hAAAA);
    sample(16'h5555);
    send_item(OP_READ, '0, 4'd0, 3'd0);
    send_item(OP_READ, '0, 4'd0, 3'd1);
    send_item(OP_READ, '0, 4'd0, 3'd2);
    send_item(OP_READ, '0, 4'd15, 3'd3);
    send_item(OP_READ, '0, 4'd1, 3'd7);
    // rising only, upper byte masked
    set_enables(16'hFFFF, 16'h0000, 16'h00FF);
    sample(16'hFFFF);
    sample(16'h0000);
    sample(16'hFFFF);
    send_item(OP_READ, '0, 4'd8, 3'd0);
    send_item(OP_READ, '0, 4'd7, 3'd3);
    // falling only
    set_enables(16'h0000, 16'hFFFF, 16'hFFFF);
    sample(16'h0000);
    send_item(OP_READ, '0, 4'd3, 3'd5);
    send_item(OP_READ, '0, 4'd12, 3'd2);
    release_input();
  endtask

  // Random samples and reads over several enable settings
  task automatic test_random_traffic();
    logic [CFG_W-1:0] r, f, l;
    logic [PIN_W-1:0] pins;
    int phase, n;
    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin r = 16'hFFFF; f = 16'hFFFF; l = 16'hFFFF; end
        1: begin r = 16'h0000; f = 16'h0000; l = 16'h0000; end
        2: begin r = 16'hFFFF; f = 16'h0000; l = 16'($urandom); end
        3: begin r = 16'h0000; f = 16'hFFFF; l = 16'hFFFF; end
        4: begin r = 16'($urandom); f = 16'($urandom); l = 16'($urandom); end
        default: begin r = 16'($urandom); f = 16'($urandom); l = 16'hFFFF; end
      endcase
      set_enables(r, f, l);
      for (n = 0; n < 250; n++) begin
        // switch between busy stretches and idling every 50 items
        if (n % 50 == 0) begin
          gap_max   = ($urandom_range(0, 2) == 0) ? 0 : 14;
          stall_max = ($urandom_range(0, 2) == 0) ? 0 : 14;
        end
        if ($urandom_range(0, 9) < 7) begin
          case ($urandom_range(0, 3))
            0: pins = 16'($urandom);
            1: pins = pin_drive ^ (16'd1 << $urandom_range(0, 15));
            2: pins = pin_drive ^ 16'($urandom & $urandom);
            default: pins = ($urandom_range(0, 1) == 0) ? pin_drive : ~pin_drive;
          endcase
          sample(pins);
        end else begin
          send_item(OP_READ, 16'($urandom), 4'($urandom_range(0, 15)),
                    3'($urandom_range(0, 7)));
        end
      end
    end
    release_input();
  endtask

  // Receiver holds off while items keep coming, so the input stalls
  task automatic test_backpressure();
    int n;
    set_enables(16'hFFFF, 16'hFFFF, 16'hFFFF);
    gap_max = 0;
    stall_max = 0;
    hold_seq++;
    for (n = 0; n < 40; n++) begin
      if (n % 4 == 3)
        send_item(OP_READ, '0, 4'($urandom_range(0, 15)), 3'($urandom_range(0, 7)));
      else
        sample(16'($urandom));
    end
    release_input();
  endtask

  // Long receiver hold, counted in cycles
  always @(posedge clk) begin
    int unsigned hold_left, hold_seen;
    if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      hold_active <= 1'b1;
    end else begin
      hold_active <= 1'b0;
    end
  end

  // Result side: pace out_tready, check each item taken
  always @(posedge clk) begin
    capture_result_t got, want;
    int unsigned ready_wait;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (predicted_records.size() == 0) begin
        note_failure($sformatf("unexpected result %036h", out_tdata));
      end else begin
        want = predicted_records.pop_front();
        check_field("captured_lines", OUT_W'(want.captured_lines),
                    OUT_W'(got.captured_lines));
        check_field("last_time", want.last_time, got.last_time);
        check_field("previous_time", want.previous_time, got.previous_time);
        check_field("event_count", want.event_count, got.event_count);
        check_field("interval_value", want.interval_value, got.interval_value);
      end
      ready_wait = $urandom_range(0, stall_max);
    end
    if (hold_active) begin
      out_tready <= 1'b0;
    end else if (ready_wait != 0) begin
      ready_wait--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  initial begin
    int i, j;
    rise_en = '0;
    fall_en = '0;
    line_en = '0;
    tick_now = '0;
    prev_pins = '0;
    for (i = 0; i < LINES; i++) begin
      edge_last[i] = '0;
      edge_prev[i] = '0;
      edge_count[i] = '0;
      for (j = 0; j < HIST_DEPTH; j++) interval_hist[i][j] = '0;
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_directed_edges();
    test_random_traffic();
    test_backpressure();

    wait_drained();
    repeat (4 * LATENCY) @(posedge clk);
    if (predicted_records.size() != 0)
      note_failure($sformatf("%0d results never arrived", predicted_records.size()));
    if (fail_count == 0)
      $display("testbench passed");
    else
      $display("testbench failed");
    $finish;
  end

endmodule
